// File: rtl/pfa_pkg.sv
// Package for the page frame allocator: command, status and state codes,
// and the packed transaction types. No dependencies.
package pfa_pkg;

  localparam int unsigned FieldW = 48;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_ALLOC  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_NO_FREE    = 3'd3,
    ST_FULL       = 3'd4,
    ST_LOCAL      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CUT,
    S_INS_CLR,
    S_AL_REG,
    S_AL_RD,
    S_AL_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              command;
    logic [FieldW-1:0] range_base;
    logic [FieldW-1:0] byte_count;
    logic              memory_kind;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [FieldW-1:0] page_address;
    logic [4:0]        regions_added;
  } rsp_t;

endpackage

// File: rtl/pfa_bitmap.sv
// In-use bitmap of the page frame allocator: one synchronous memory of
// 64-bit words, one read and one write port, registered read data.
// Depends on nothing.
module pfa_bitmap #(
  parameter int unsigned Words = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i
);
  logic [63:0] mem_q [Words];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end
endmodule

// File: rtl/page_frame_allocator.sv
// Page frame allocator, top level: region table, control sequencer and the
// in-use bitmap memory. Depends on pfa_pkg and pfa_bitmap.
//
// Accepts one command while busy is low and returns exactly one result,
// on a one-cycle done_o strobe; results cannot be held off. An insert cuts
// one region at a time and clears its in-use bits, PAGES_PER_REGION/64
// words (rounded up) per region, through the single bitmap write port,
// then closes with a cut check and the result strobe.
// An alloc walks the regions in order and reads the bitmap one 64-bit word
// at a time, each read followed by a check before the next word is read.
// The region table lives in registers (MAX_REGIONS entries). No clearing
// pass is needed after reset: bits of a region are cleared when it is
// inserted, and unused bits beyond a region's page count are never
// allocated.
module page_frame_allocator #(
  parameter int unsigned PAGE_SHIFT       = 12,
  parameter int unsigned PAGES_PER_REGION = 1024,
  parameter int unsigned MAX_REGIONS      = 16,
  parameter int unsigned ADDR_BITS        = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pfa_pkg::req_t req_i,
  output logic          done_o,
  output pfa_pkg::rsp_t rsp_o
);
  import pfa_pkg::*;

  localparam int unsigned WPR   = (PAGES_PER_REGION + 63) / 64;  // words/region
  localparam int unsigned WORDS = WPR * MAX_REGIONS;
  localparam int unsigned BAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned WW    = (WPR > 1) ? $clog2(WPR) + 1 : 1;
  localparam int unsigned RW    = $clog2(MAX_REGIONS + 1);
  localparam int unsigned RIW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW    = $clog2(PAGES_PER_REGION + 1);
  localparam int unsigned BIG   = (ADDR_BITS > FieldW) ? ADDR_BITS : FieldW;
  localparam int unsigned PW    = BIG - PAGE_SHIFT + 2;  // page counts

  // Region table.
  logic [ADDR_BITS-1:0] first_q [MAX_REGIONS];
  logic [CW-1:0]        count_q [MAX_REGIONS];
  logic [RW-1:0]        total_q, total_d;

  state_e state_q, state_d;

  logic [ADDR_BITS-1:0] base_q, base_d;     // page-aligned cursor
  logic [PW-1:0]        pages_q, pages_d;   // remaining pages (floor)
  logic [4:0]           added_q, added_d;
  logic [2:0]           stat_q, stat_d;
  logic [FieldW-1:0]    addr_q, addr_d;
  logic [RIW-1:0]       reg_q, reg_d;       // region index
  logic [WW-1:0]        word_q, word_d;     // word within region
  logic [CW-1:0]        cnt_q;              // page count of scanned region
  logic [ADDR_BITS-1:0] fp_q;

  // Bitmap port.
  logic            rd_en, wr_en;
  logic [BAW-1:0]  rd_addr, wr_addr;
  logic [63:0]     rd_data, wr_data;

  pfa_bitmap #(.Words(WORDS), .AW(BAW)) u_bitmap (
    .clk_i, .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  logic [BAW-1:0] word_addr;
  assign word_addr = BAW'(reg_q * WPR + word_q);

  // Check stage: valid pages in the fetched word, first free one.
  logic [63:0] valid_m, free_m;
  logic [5:0]  free_idx;
  logic        found;
  logic [CW+6:0] page_lo;
  always_comb begin
    page_lo = (CW+7)'(word_q) << 6;
    for (int b = 0; b < 64; b++) begin
      valid_m[b] = ((CW+7)'(page_lo + (CW+7)'(b)) < (CW+7)'(cnt_q));
    end
    free_m   = valid_m & ~rd_data;
    found    = |free_m;
    free_idx = '0;
    for (int b = 63; b >= 0; b--) begin
      if (free_m[b]) free_idx = 6'(b);
    end
  end

  // Insert cut arithmetic.
  logic [PW-1:0] body_pg;
  always_comb begin
    body_pg = pages_q - PW'(1);
    if (body_pg > PW'(PAGES_PER_REGION)) body_pg = PW'(PAGES_PER_REGION);
  end

  logic aligned, too_short;
  assign aligned   = (req_i.range_base[PAGE_SHIFT-1:0] == '0);
  assign too_short = (req_i.byte_count < FieldW'(2 << PAGE_SHIFT));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.command == CMD_ALLOC) begin
            state_d = (req_i.byte_count > FieldW'(1 << PAGE_SHIFT)) ? S_DONE :
                      S_AL_REG;
          end else if (!aligned || too_short || req_i.memory_kind) begin
            state_d = S_DONE;
          end else begin
            state_d = S_INS_CUT;
          end
        end
      end
      S_INS_CUT: begin
        if (pages_q < PW'(2) || total_q >= RW'(MAX_REGIONS)) state_d = S_DONE;
        else state_d = S_INS_CLR;
      end
      S_INS_CLR: begin
        if (word_q == WW'(WPR - 1)) state_d = S_INS_CUT;
      end
      S_AL_REG: begin
        if (RW'(reg_q) >= total_q || (MAX_REGIONS > 1 && reg_q == '0 &&
            added_q != '0)) state_d = S_DONE;
        else state_d = S_AL_RD;
      end
      S_AL_RD: state_d = S_AL_CHK;
      S_AL_CHK: begin
        if (found) state_d = S_DONE;
        else if ((CW+7)'(word_q + WW'(1)) << 6 >= (CW+7)'(cnt_q)) state_d = S_AL_REG;
        else state_d = S_AL_RD;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs. added_q doubles as the scan's "wrapped" flag.
  always_comb begin
    base_d  = base_q;
    pages_d = pages_q;
    added_d = added_q;
    stat_d  = stat_q;
    addr_d  = addr_q;
    reg_d   = reg_q;
    word_d  = word_q;
    total_d = total_q;
    rd_en   = 1'b0;
    rd_addr = word_addr;
    wr_en   = 1'b0;
    wr_addr = word_addr;
    wr_data = '0;
    unique case (state_q)
      S_IDLE: begin
        base_d  = ADDR_BITS'(req_i.range_base);
        pages_d = PW'(req_i.byte_count >> PAGE_SHIFT);
        added_d = '0;
        addr_d  = '0;
        reg_d   = '0;
        word_d  = '0;
        stat_d  = ST_OK;
        if (req_i.command == CMD_ALLOC) begin
          if (req_i.byte_count > FieldW'(1 << PAGE_SHIFT)) stat_d = ST_TOO_LARGE;
        end else if (!aligned) begin
          stat_d = ST_MISALIGNED;
        end else if (!too_short && req_i.memory_kind) begin
          stat_d = ST_LOCAL;
        end
      end
      S_INS_CUT: begin
        word_d = '0;
        reg_d  = RIW'(total_q);
        if (pages_q >= PW'(2) && total_q >= RW'(MAX_REGIONS)) stat_d = ST_FULL;
      end
      S_INS_CLR: begin
        wr_en  = 1'b1;
        word_d = word_q + WW'(1);
        if (word_q == WW'(WPR - 1)) begin
          total_d = total_q + RW'(1);
          added_d = added_q + 5'd1;
          pages_d = pages_q - PW'(1) - body_pg;
          base_d  = base_q + (ADDR_BITS'(body_pg + PW'(1)) << PAGE_SHIFT);
        end
      end
      S_AL_REG: begin
        word_d = '0;
        if (RW'(reg_q) >= total_q || (MAX_REGIONS > 1 && reg_q == '0 &&
            added_q != '0)) stat_d = ST_NO_FREE;
      end
      S_AL_RD: rd_en = 1'b1;
      S_AL_CHK: begin
        if (found) begin
          wr_en   = 1'b1;
          wr_data = rd_data | (64'd1 << free_idx);
          addr_d  = FieldW'(fp_q + (ADDR_BITS'({word_q, free_idx}) << PAGE_SHIFT));
        end else if ((CW+7)'(word_q + WW'(1)) << 6 >= (CW+7)'(cnt_q)) begin
          reg_d = reg_q + RIW'(1);
          if (RW'(reg_q) == RW'(MAX_REGIONS - 1)) added_d = 5'd1;
        end else begin
          word_d = word_q + WW'(1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    pages_q <= pages_d;
    added_q <= added_d;
    stat_q  <= stat_d;
    addr_q  <= addr_d;
    reg_q   <= reg_d;
    word_q  <= word_d;
    if (state_q == S_AL_REG) begin
      cnt_q <= count_q[reg_q];
      fp_q  <= first_q[reg_q];
    end
    if (state_q == S_INS_CUT && state_d == S_INS_CLR) begin
      first_q[RIW'(total_q)] <= base_q + ADDR_BITS'(1 << PAGE_SHIFT);
      count_q[RIW'(total_q)] <= CW'(body_pg);
    end
  end

  assign busy                = (state_q != S_IDLE);
  assign done_o              = (state_q == S_DONE);
  assign rsp_o.status        = stat_q;
  assign rsp_o.page_address  = (stat_q == ST_OK) ? addr_q : '0;
  assign rsp_o.regions_added = (stat_q == ST_OK || stat_q == ST_FULL) &&
                               (addr_q == '0) ? added_q : '0;
endmodule
